// ===== hdl/tws_pkg.sv =====
package tws_pkg;

	// Default pool size and alphabet size.
	localparam int NODES_DEF    = 1024;
	localparam int ALPHABET_DEF = 26;

	// Character code of the first letter of the alphabet.
	localparam logic [7:0] CHAR_BASE = 8'd97;

	// Depth of the queue between the front and back parts (power of two).
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Word commands.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_PREFIX = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCHAR = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// One classified character item as it travels from the front to the back.
	typedef struct packed {
		logic       first;
		cmd_t       cmd;
		logic       empty;
		logic       last;
		logic       chr_ok;
		logic [7:0] ofs;
	} tws_item_t;

endpackage

// ===== hdl/tws_front.sv =====
module tws_front #(
	parameter int ALPHABET = tws_pkg::ALPHABET_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        cmd,
	input  logic [7:0]        char_code,
	input  logic              empty_word,
	input  logic              last,
	output tws_pkg::tws_item_t item
);
	import tws_pkg::*;

	logic       word_active_q;
	cmd_t       word_cmd_q;
	logic [7:0] ofs;

	// Track whether a word is in progress and hold the command of its first item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_active_q <= 1'b0;
			word_cmd_q    <= CMD_INSERT;
		end else if (push) begin
			word_active_q <= !last;
			if (!word_active_q) begin
				word_cmd_q <= cmd_t'(cmd);
			end
		end
	end

	// Classify the character against the alphabet range.
	assign ofs = char_code - CHAR_BASE;

	always_comb begin
		item.first  = !word_active_q;
		item.cmd    = word_active_q ? word_cmd_q : cmd_t'(cmd);
		item.empty  = empty_word;
		item.last   = last;
		item.chr_ok = (char_code >= CHAR_BASE) && (ofs < 8'(ALPHABET));
		item.ofs    = ofs;
	end

endmodule

// ===== hdl/tws_queue.sv =====
module tws_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tws_pkg::tws_item_t wr_item,
	input  logic               pop,
	output tws_pkg::tws_item_t head,
	output logic               nonempty,
	output logic               full
);
	import tws_pkg::*;

	tws_item_t        slots_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	// Pointers wrap on their own since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage for queued character items.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	assign head     = slots_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign full     = (count_q == QCW'(QDEPTH));

endmodule

// ===== hdl/tws_back.sv =====
module tws_back #(
	parameter int NODES    = tws_pkg::NODES_DEF,
	parameter int ALPHABET = tws_pkg::ALPHABET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tws_pkg::tws_item_t head,
	input  logic               nonempty,
	output logic               pop,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic [7:0]         prefix_len
);
	import tws_pkg::*;

	localparam int NW    = $clog2(NODES);
	localparam int CNT_W = $clog2(NODES + 1);
	localparam int SW    = $clog2(NODES * ALPHABET);
	localparam int IW    = $clog2(ALPHABET);

	typedef enum logic [4:0] {
		BK_INIT   = 5'b00001,
		BK_IDLE   = 5'b00010,
		BK_STEP   = 5'b00100,
		BK_GROW   = 5'b01000,
		BK_REPORT = 5'b10000
	} bk_state_t;

	bk_state_t        state_q;
	tws_item_t        itm_q;
	logic [SW-1:0]    slot_q;
	logic [NW-1:0]    cursor_q;
	logic             stopped_q;
	logic [1:0]       status_q;
	logic [7:0]       match_q;
	logic [CNT_W-1:0] nodes_used_q;

	// Node memories.
	logic [ALPHABET-1:0] mask_mem [NODES];
	logic [NW-1:0]       ptr_mem [NODES * ALPHABET];
	logic                end_mem [NODES];

	logic [ALPHABET-1:0] mask_rd;
	logic [NW-1:0]       ptr_rd;
	logic                end_rd;

	logic                mask_re, mask_we;
	logic [NW-1:0]       mask_ra, mask_wa;
	logic [ALPHABET-1:0] mask_wd;
	logic                ptr_re, ptr_we;
	logic [SW-1:0]       slot;
	logic                end_re, end_we, end_wd;
	logic [NW-1:0]       end_wa;

	logic [NW-1:0]       h_cur;
	logic [IW-1:0]       idx;
	logic                act, hit, pool_full, alloc, mark;
	logic [NW-1:0]       nxt_cursor;
	logic [1:0]          nxt_status;
	logic                nxt_stop;
	logic [7:0]          nxt_match;

	// Fetch side: the queue head starts its mask and pointer reads at once.
	assign h_cur   = head.first ? '0 : cursor_q;
	assign slot    = SW'(h_cur) * SW'(ALPHABET) + SW'(head.ofs[IW-1:0]);
	assign pop     = (state_q == BK_IDLE) && nonempty;
	assign mask_re = pop;
	assign ptr_re  = pop;
	assign mask_ra = h_cur;

	// Step decision for one character, using the data fetched last cycle.
	assign idx       = itm_q.ofs[IW-1:0];
	assign hit       = mask_rd[idx];
	assign pool_full = nodes_used_q >= CNT_W'(NODES);
	assign act       = !itm_q.empty && !stopped_q && (itm_q.cmd != CMD_CLEAR);

	always_comb begin
		nxt_cursor = cursor_q;
		nxt_status = status_q;
		nxt_stop   = stopped_q;
		nxt_match  = match_q;
		alloc      = 1'b0;
		if (act) begin
			if (!itm_q.chr_ok) begin
				nxt_status = ST_BADCHAR;
				nxt_stop   = 1'b1;
			end else if (hit) begin
				nxt_cursor = ptr_rd;
				if ((itm_q.cmd == CMD_PREFIX) && (match_q != 8'hFF)) begin
					nxt_match = match_q + 8'd1;
				end
			end else if (itm_q.cmd != CMD_INSERT) begin
				nxt_stop = 1'b1;
			end else if (pool_full) begin
				nxt_status = ST_FULL;
				nxt_stop   = 1'b1;
			end else begin
				alloc      = 1'b1;
				nxt_cursor = nodes_used_q[NW-1:0];
			end
		end
	end

	assign mark = itm_q.last && (itm_q.cmd == CMD_INSERT) && (nxt_status == ST_OK);

	// Write port selection for the mask and end-mark memories.
	always_comb begin
		mask_we = 1'b0;
		mask_wa = cursor_q;
		mask_wd = '0;
		end_we  = 1'b0;
		end_wa  = nxt_cursor;
		end_wd  = 1'b0;
		case (state_q)
			BK_INIT: begin
				mask_we = 1'b1;
				mask_wa = '0;
				end_we  = 1'b1;
				end_wa  = '0;
			end
			BK_STEP: begin
				mask_we = alloc;
				mask_wd = mask_rd | (ALPHABET'(1) << idx);
				end_we  = alloc || mark;
				end_wd  = mark;
			end
			BK_GROW: begin
				mask_we = 1'b1;
			end
			BK_REPORT: begin
				if (itm_q.cmd == CMD_CLEAR) begin
					mask_we = 1'b1;
					mask_wa = '0;
					end_we  = 1'b1;
					end_wa  = '0;
				end
			end
			default: begin
				mask_we = 1'b0;
			end
		endcase
	end

	assign ptr_we = (state_q == BK_STEP) && alloc;
	assign end_re = (state_q == BK_STEP);

	// Child-present mask memory.
	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[mask_wa] <= mask_wd;
		end
		if (mask_re) begin
			mask_rd <= mask_mem[mask_ra];
		end
	end

	// Child pointer memory.
	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[slot_q] <= nodes_used_q[NW-1:0];
		end
		if (ptr_re) begin
			ptr_rd <= ptr_mem[slot];
		end
	end

	// End-of-word mark memory.
	always_ff @(posedge clk) begin
		if (end_we) begin
			end_mem[end_wa] <= end_wd;
		end
		if (end_re) begin
			end_rd <= end_mem[nxt_cursor];
		end
	end

	// Item and slot address captured at the pop.
	always_ff @(posedge clk) begin
		if (pop) begin
			itm_q  <= head;
			slot_q <= slot;
		end
	end

	// Sequencer and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_INIT;
			cursor_q     <= '0;
			stopped_q    <= 1'b0;
			status_q     <= ST_OK;
			match_q      <= '0;
			nodes_used_q <= CNT_W'(1);
		end else begin
			case (state_q)
				BK_INIT: begin
					state_q <= BK_IDLE;
				end
				BK_IDLE: begin
					if (nonempty) begin
						if (head.first) begin
							cursor_q  <= '0;
							stopped_q <= 1'b0;
							status_q  <= ST_OK;
							match_q   <= '0;
						end
						state_q <= BK_STEP;
					end
				end
				BK_STEP: begin
					cursor_q  <= nxt_cursor;
					stopped_q <= nxt_stop;
					status_q  <= nxt_status;
					match_q   <= nxt_match;
					if (alloc) begin
						nodes_used_q <= nodes_used_q + 1'b1;
						state_q      <= BK_GROW;
					end else if (itm_q.last) begin
						state_q <= BK_REPORT;
					end else begin
						state_q <= BK_IDLE;
					end
				end
				BK_GROW: begin
					state_q <= itm_q.last ? BK_REPORT : BK_IDLE;
				end
				BK_REPORT: begin
					if (itm_q.cmd == CMD_CLEAR) begin
						nodes_used_q <= CNT_W'(1);
					end
					state_q <= BK_IDLE;
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Result word, shown for the single cycle spent in the report state.
	assign done       = (state_q == BK_REPORT);
	assign status     = (itm_q.cmd == CMD_CLEAR) ? ST_OK : status_q;
	assign found      = (itm_q.cmd == CMD_SEARCH) && (status_q == ST_OK) && !stopped_q && end_rd;
	assign prefix_len = ((itm_q.cmd == CMD_PREFIX) && (status_q == ST_OK)) ? match_q : 8'd0;

endmodule

// ===== hdl/trie_word_store.sv =====
// Flow: an accepted item waits in the queue until the back end pops it in the idle
// state and starts its node mask and pointer reads; the step state walks the character,
// the grow state follows when it adds a node, and the report state gives a word's result
// after its last item. The next character is popped only once the back end is idle again.
// Reset: asynchronous, active low; the root node is cleared in the init state entered at
// reset (a clear command does the same at its result). The receiver cannot stall.
module trie_word_store #(
	parameter int NODES    = tws_pkg::NODES_DEF,
	parameter int ALPHABET = tws_pkg::ALPHABET_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic       empty_word,
	input  logic       last,
	output logic       done,
	output logic [1:0] status,
	output logic       found,
	output logic [7:0] prefix_len
);
	import tws_pkg::*;

	tws_item_t f_item;
	tws_item_t q_head;
	logic      push;
	logic      q_nonempty;
	logic      q_full;
	logic      q_pop;

	// A word item is taken whenever the queue has room.
	assign busy = q_full;
	assign push = start && !busy;

	tws_front #(
		.ALPHABET (ALPHABET)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd        (cmd),
		.char_code  (char_code),
		.empty_word (empty_word),
		.last       (last),
		.item       (f_item)
	);

	tws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.pop      (q_pop),
		.head     (q_head),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	tws_back #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.nonempty   (q_nonempty),
		.pop        (q_pop),
		.done       (done),
		.status     (status),
		.found      (found),
		.prefix_len (prefix_len)
	);

	// Results never come in adjacent cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in adjacent cycles");

	// A search hit always carries an ok status and no match length.
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (status == ST_OK && prefix_len == 8'd0))
		else $error("search hit with bad status or match length");

	// An item pushed into an empty queue is at the head on the next cycle.
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_nonempty) |=> q_nonempty)
		else $error("accepted item lost before reaching the queue head");

endmodule
